@@ rtl/ps2_mouse_device_unit_defines.svh @@
// assertion macros used by the checker file
`ifndef PS2_MOUSE_DEVICE_UNIT_DEFINES_SVH
`define PS2_MOUSE_DEVICE_UNIT_DEFINES_SVH

// clocked check, held off while reset is high
`define PS2MD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also runs during reset
`define PS2MD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/ps2md_pkg.sv @@
package ps2md_pkg;

  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_READ   = 2'd1,
    ACT_MOTION = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // host commands
  localparam logic [7:0] CMD_RESET    = 8'hFF;
  localparam logic [7:0] CMD_GET_ID   = 8'hF2;
  localparam logic [7:0] CMD_STATUS   = 8'hE9;
  localparam logic [7:0] CMD_SET_RATE = 8'hF3;
  localparam logic [7:0] CMD_SET_RES  = 8'hE8;
  localparam logic [7:0] CMD_ENABLE   = 8'hF4;
  localparam logic [7:0] CMD_DISABLE  = 8'hF5;
  localparam logic [7:0] CMD_DEFAULTS = 8'hF6;

  // device responses
  localparam logic [7:0] RSP_ACK         = 8'hFA;
  localparam logic [7:0] RSP_SELF_TEST   = 8'hAA;
  localparam logic [7:0] RSP_DEVICE_ID   = 8'h00;
  localparam logic [7:0] RSP_STATUS_FLG  = 8'h00;
  localparam logic [7:0] RSP_STATUS_RES  = 8'h02;
  localparam logic [7:0] RSP_STATUS_RATE = 8'h64;

  // first byte of a motion packet always carries this bit
  localparam logic [7:0] PKT_SYNC = 8'h08;

  localparam int unsigned MAX_PUSH   = 4;
  localparam int unsigned MOTION_LEN = 3;

  // saturate a motion delta to -127..127 and return its low byte
  function automatic logic [7:0] clamp_delta(input logic signed [16:0] v);
    logic [7:0] r;
    if (v > 17'sd127) begin
      r = 8'h7F;
    end else if (v < -17'sd127) begin
      r = 8'h81;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/ps2md_in_if.sv @@
interface ps2md_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [7:0]         cmd_byte;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic [1:0]         buttons;

  modport source (output valid, output action, output cmd_byte, output delta_x,
                  output delta_y, output buttons, input ready);
  modport sink (input valid, input action, input cmd_byte, input delta_x,
                input delta_y, input buttons, output ready);
endinterface

@@ rtl/ps2md_out_if.sv @@
interface ps2md_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       byte_valid;
  logic       irq_pulse;
  logic       data_pending;
  logic       overflow;

  modport source (output valid, output read_byte, output byte_valid, output irq_pulse,
                  output data_pending, output overflow, input ready);
  modport sink (input valid, input read_byte, input byte_valid, input irq_pulse,
                input data_pending, input overflow, output ready);
endinterface

@@ rtl/ps2_mouse_device_unit.sv @@
// the result of an item is registered and shown in the cycle after the item is accepted
// throughput: one item per cycle; the queue update and result are one register stage
// req.ready drops only while a result waits and rsp.ready is low, or during reset
// reset (rst, synchronous): empties the queue, clears reporting and parameter wait,
// drops the result; queue storage itself is not cleared and is never read unwritten
module ps2_mouse_device_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  ps2md_in_if.sink   req,
  ps2md_out_if.source rsp
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // queue storage and pointers
  logic [7:0]    store [QUEUE_DEPTH];
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          reporting, reporting_next;
  logic          awaiting, awaiting_next;

  // result register
  logic       rsp_valid;
  logic [7:0] rsp_read_byte;
  logic       rsp_byte_valid;
  logic       rsp_irq;
  logic       rsp_pending;
  logic       rsp_overflow;

  logic accept;

  // per-item work
  logic [7:0]    push_byte [ps2md_pkg::MAX_PUSH];
  logic [AW-1:0] wr_addr [ps2md_pkg::MAX_PUSH];
  logic [2:0]    n_req, n_store;
  logic [AW-1:0] base_head;
  logic [CW-1:0] base_count;
  logic [CW-1:0] free_slots;
  logic [AW:0]   tail_sum, slot_sum, head_sum;
  logic [AW-1:0] tail;
  logic          pop;
  logic          irq;
  logic          ovf;
  logic signed [16:0] dx_ext, dy_neg;

  // the block takes an item whenever the result register is free or being emptied
  assign req.ready = !rst && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign dx_ext = 17'(req.delta_x);
  assign dy_neg = -17'(req.delta_y);

  always_comb begin
    for (int k = 0; k < ps2md_pkg::MAX_PUSH; k++) begin
      push_byte[k] = 8'h00;
    end
    n_req          = 3'd0;
    base_head      = head;
    base_count     = count;
    reporting_next = reporting;
    awaiting_next  = awaiting;
    pop            = 1'b0;
    irq            = 1'b0;
    ovf            = 1'b0;

    unique case (req.action)
      ps2md_pkg::ACT_CMD: begin
        if (awaiting) begin
          // parameter byte of set rate / set resolution: ack only
          awaiting_next = 1'b0;
          push_byte[0]  = ps2md_pkg::RSP_ACK;
          n_req         = 3'd1;
        end else if (req.cmd_byte == ps2md_pkg::CMD_RESET) begin
          // device reset drops everything queued before its reply
          base_head      = '0;
          base_count     = '0;
          awaiting_next  = 1'b0;
          reporting_next = 1'b0;
          push_byte[0]   = ps2md_pkg::RSP_ACK;
          push_byte[1]   = ps2md_pkg::RSP_SELF_TEST;
          push_byte[2]   = ps2md_pkg::RSP_DEVICE_ID;
          n_req          = 3'd3;
        end else begin
          push_byte[0] = ps2md_pkg::RSP_ACK;
          n_req        = 3'd1;
          unique case (req.cmd_byte) inside
            ps2md_pkg::CMD_GET_ID: begin
              push_byte[1] = ps2md_pkg::RSP_DEVICE_ID;
              n_req        = 3'd2;
            end
            ps2md_pkg::CMD_SET_RATE, ps2md_pkg::CMD_SET_RES: begin
              awaiting_next = 1'b1;
            end
            ps2md_pkg::CMD_STATUS: begin
              push_byte[1] = ps2md_pkg::RSP_STATUS_FLG;
              push_byte[2] = ps2md_pkg::RSP_STATUS_RES;
              push_byte[3] = ps2md_pkg::RSP_STATUS_RATE;
              n_req        = 3'd4;
            end
            ps2md_pkg::CMD_ENABLE: begin
              reporting_next = 1'b1;
            end
            ps2md_pkg::CMD_DISABLE, ps2md_pkg::CMD_DEFAULTS: begin
              reporting_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ps2md_pkg::ACT_READ: begin
        if (count != '0) begin
          pop = 1'b1;
          // interrupt again only if more bytes remain after this one
          irq = reporting && (count > CW'(1));
        end
      end
      ps2md_pkg::ACT_MOTION: begin
        if (reporting) begin
          if (CW'(QUEUE_DEPTH) - count < CW'(ps2md_pkg::MOTION_LEN)) begin
            // packet is dropped whole
            ovf = 1'b1;
          end else begin
            push_byte[0] = ps2md_pkg::PKT_SYNC | {6'd0, req.buttons};
            push_byte[1] = ps2md_pkg::clamp_delta(dx_ext);
            push_byte[2] = ps2md_pkg::clamp_delta(dy_neg);
            n_req        = 3'(ps2md_pkg::MOTION_LEN);
            irq          = (count == '0);
          end
        end
      end
      default: begin
      end
    endcase

    // command replies keep what fits and flag the rest
    free_slots = CW'(QUEUE_DEPTH) - base_count;
    if (CW'(n_req) > free_slots) begin
      n_store = free_slots[2:0];
      ovf     = 1'b1;
    end else begin
      n_store = n_req;
    end

    tail_sum = {1'b0, base_head} + (AW + 1)'(base_count);
    if (tail_sum >= (AW + 1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (AW + 1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[AW-1:0];

    for (int k = 0; k < ps2md_pkg::MAX_PUSH; k++) begin
      slot_sum = {1'b0, tail} + (AW + 1)'(k);
      if (slot_sum >= (AW + 1)'(QUEUE_DEPTH)) begin
        slot_sum = slot_sum - (AW + 1)'(QUEUE_DEPTH);
      end
      wr_addr[k] = slot_sum[AW-1:0];
    end

    // pop only happens on reads, which never push
    head_sum = {1'b0, base_head} + (AW + 1)'(pop);
    if (head_sum >= (AW + 1)'(QUEUE_DEPTH)) begin
      head_sum = head_sum - (AW + 1)'(QUEUE_DEPTH);
    end
    head_next  = head_sum[AW-1:0];
    count_next = base_count + CW'(n_store) - CW'(pop);
  end

  // queue storage, up to four writes per item
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < ps2md_pkg::MAX_PUSH; k++) begin
        if (3'(k) < n_store) begin
          store[wr_addr[k]] <= push_byte[k];
        end
      end
    end
  end

  // queue control and device flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      reporting <= 1'b0;
      awaiting  <= 1'b0;
    end else if (accept) begin
      head      <= head_next;
      count     <= count_next;
      reporting <= reporting_next;
      awaiting  <= awaiting_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // the popped byte is read from the queue at the same edge
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_read_byte  <= pop ? store[head] : 8'h00;
      rsp_byte_valid <= pop;
      rsp_irq        <= irq;
      rsp_pending    <= (count_next != '0);
      rsp_overflow   <= ovf;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.read_byte    = rsp_read_byte;
  assign rsp.byte_valid   = rsp_byte_valid;
  assign rsp.irq_pulse    = rsp_irq;
  assign rsp.data_pending = rsp_pending;
  assign rsp.overflow     = rsp_overflow;

endmodule

@@ rtl/ps2md_checker.sv @@
`include "ps2_mouse_device_unit_defines.svh"

module ps2md_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_action,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_byte,
  input logic       out_byte_valid,
  input logic       out_irq_pulse,
  input logic       out_data_pending,
  input logic       out_overflow
);

  logic in_accept;
  assign in_accept = in_valid && in_ready;

  // a waiting result is not lost or changed
  `PS2MD_ASSERT(a_rsp_hold, out_valid && !out_ready |=> out_valid && $stable(out_read_byte) && $stable(out_overflow), "result changed while stalled")

  // every accepted item yields a result on the next cycle
  `PS2MD_ASSERT(a_one_result, in_accept |=> out_valid, "accepted item gave no result")

  // a read never overflows, and its interrupt means bytes remain
  `PS2MD_ASSERT(a_read_result, in_accept && (in_action == ps2md_pkg::ACT_READ) |=> !out_overflow && (!out_irq_pulse || out_data_pending), "bad read result")

  // commands pop nothing and never interrupt
  `PS2MD_ASSERT(a_cmd_result, in_accept && (in_action == ps2md_pkg::ACT_CMD) |=> !out_irq_pulse && !out_byte_valid && (out_read_byte == 8'h00), "bad command result")

  // nothing is taken in during reset
  `PS2MD_ASSERT_ALWAYS(a_rst_idle, rst |-> !in_ready, "item taken during reset")

endmodule

bind ps2_mouse_device_unit ps2md_checker u_ps2md_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (req.valid),
  .in_ready         (req.ready),
  .in_action        (req.action),
  .out_valid        (rsp.valid),
  .out_ready        (rsp.ready),
  .out_read_byte    (rsp.read_byte),
  .out_byte_valid   (rsp.byte_valid),
  .out_irq_pulse    (rsp.irq_pulse),
  .out_data_pending (rsp.data_pending),
  .out_overflow     (rsp.overflow)
);

@@ tb/tb_ps2_mouse_device_unit.sv @@
module tb_ps2_mouse_device_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = 16;
  localparam int STALL_MAX = 18;       // longest idle draw on either side
  localparam int WATCHDOG_LIMIT = 400; // cycles with no handshake at all
  localparam int RANDOM_ITEMS = 1500;
  localparam int REPORT_MAX = 10;

  // one host action as it goes into the device
  typedef struct packed {
    ps2md_pkg::action_t action;
    logic [7:0]         cmd_byte;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [1:0]         buttons;
  } host_req_t;

  // what the device reports for one action
  typedef struct packed {
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       irq_pulse;
    logic       data_pending;
    logic       overflow;
  } dev_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ps2md_in_if  req_if ();
  ps2md_out_if rsp_if ();

  ps2_mouse_device_unit #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #4 clk = ~clk;
  end

  // mirror of the device state: byte queue plus the two mode flags
  logic [7:0]  mir_fifo [QDEPTH];
  int unsigned mir_head = 0;
  int unsigned mir_count = 0;
  bit          mir_reporting = 1'b0;
  bit          mir_param_wait = 1'b0;

  dev_rsp_t rsp_expected_q[$];   // predicted results, oldest first
  int mismatches = 0;
  int sent_items = 0;            // accepted items that do something
  int src_calm = 0;              // remaining back-to-back items on the host side
  int snk_calm = 0;              // remaining zero-stall results on the reader side
  int idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // device mirror
  // ---------------------------------------------------------------------------

  function automatic bit mir_push(input logic [7:0] b);
    if (mir_count >= QDEPTH) return 1'b0;
    mir_fifo[(mir_head + mir_count) % QDEPTH] = b;
    mir_count++;
    return 1'b1;
  endfunction

  function automatic logic [7:0] mir_pop();
    logic [7:0] b;
    b = mir_fifo[mir_head];
    mir_head = (mir_head + 1) % QDEPTH;
    mir_count--;
    return b;
  endfunction

  // saturate to -127..127, keep the two's complement byte
  function automatic logic [7:0] sat_delta(input int v);
    if (v > 127) v = 127;
    else if (v < -127) v = -127;
    return v[7:0];
  endfunction

  // advance the mirror by one action and return the result it should give
  function automatic dev_rsp_t mouse_step(input host_req_t it);
    dev_rsp_t r;
    bit ok;
    bit fifo_idle;
    r = '0;
    ok = 1'b1;
    case (it.action)
      ps2md_pkg::ACT_CMD: begin
        if (mir_param_wait) begin
          // any byte is the parameter, only acknowledged
          mir_param_wait = 1'b0;
          ok = mir_push(ps2md_pkg::RSP_ACK);
        end else if (it.cmd_byte == ps2md_pkg::CMD_RESET) begin
          // flush first, then the self-test reply
          mir_head = 0;
          mir_count = 0;
          mir_param_wait = 1'b0;
          mir_reporting = 1'b0;
          ok &= mir_push(ps2md_pkg::RSP_ACK);
          ok &= mir_push(ps2md_pkg::RSP_SELF_TEST);
          ok &= mir_push(ps2md_pkg::RSP_DEVICE_ID);
        end else begin
          ok &= mir_push(ps2md_pkg::RSP_ACK);
          case (it.cmd_byte)
            ps2md_pkg::CMD_GET_ID: ok &= mir_push(ps2md_pkg::RSP_DEVICE_ID);
            ps2md_pkg::CMD_SET_RATE, ps2md_pkg::CMD_SET_RES: mir_param_wait = 1'b1;
            ps2md_pkg::CMD_STATUS: begin
              ok &= mir_push(ps2md_pkg::RSP_STATUS_FLG);
              ok &= mir_push(ps2md_pkg::RSP_STATUS_RES);
              ok &= mir_push(ps2md_pkg::RSP_STATUS_RATE);
            end
            ps2md_pkg::CMD_ENABLE: mir_reporting = 1'b1;
            ps2md_pkg::CMD_DISABLE, ps2md_pkg::CMD_DEFAULTS: mir_reporting = 1'b0;
            default: ;
          endcase
        end
        r.overflow = !ok;
      end
      ps2md_pkg::ACT_READ: begin
        if (mir_count != 0) begin
          r.read_byte = mir_pop();
          r.byte_valid = 1'b1;
          r.irq_pulse = mir_reporting && (mir_count != 0);
        end
      end
      ps2md_pkg::ACT_MOTION: begin
        if (mir_reporting) begin
          if (QDEPTH - mir_count < ps2md_pkg::MOTION_LEN) begin
            // packet goes whole or not at all
            r.overflow = 1'b1;
          end else begin
            fifo_idle = (mir_count == 0);
            void'(mir_push(ps2md_pkg::PKT_SYNC | {6'b0, it.buttons}));
            void'(mir_push(sat_delta(int'($signed(it.delta_x)))));
            void'(mir_push(sat_delta(-int'($signed(it.delta_y)))));
            r.irq_pulse = fifo_idle;
          end
        end
      end
      default: ;
    endcase
    r.data_pending = (mir_count != 0);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle draw per item, with occasional runs of no idling at all
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, STALL_MAX);
    end
  endtask

  // mostly small moves, sometimes anything in 16 bits
  function automatic logic signed [15:0] rand_delta();
    int v;
    if ($urandom_range(0, 3) == 0) v = int'($urandom);
    else v = int'($urandom_range(0, 320)) - 160;
    return v[15:0];
  endfunction

  // fields the action does not use are random too, they must be ignored
  function automatic host_req_t rand_item(input ps2md_pkg::action_t a);
    host_req_t it;
    it.action = a;
    it.cmd_byte = 8'($urandom_range(0, 255));
    it.delta_x = rand_delta();
    it.delta_y = rand_delta();
    it.buttons = 2'($urandom_range(0, 3));
    return it;
  endfunction

  // host side: idle, present the item, hold until taken, then predict
  task automatic send_item(input host_req_t it);
    int gap;
    draw_gap(src_calm, gap);
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= it.action;
    req_if.cmd_byte <= it.cmd_byte;
    req_if.delta_x  <= it.delta_x;
    req_if.delta_y  <= it.delta_y;
    req_if.buttons  <= it.buttons;
    do @(posedge clk); while (!req_if.ready);
    rsp_expected_q.push_back(mouse_step(it));
    if (it.action != ps2md_pkg::ACT_NONE) sent_items++;
  endtask

  task automatic send_cmd(input logic [7:0] b);
    host_req_t it;
    it = rand_item(ps2md_pkg::ACT_CMD);
    it.cmd_byte = b;
    send_item(it);
  endtask

  task automatic send_read();
    send_item(rand_item(ps2md_pkg::ACT_READ));
  endtask

  task automatic send_motion(input logic signed [15:0] dx, input logic signed [15:0] dy,
                             input logic [1:0] btn);
    host_req_t it;
    it = rand_item(ps2md_pkg::ACT_MOTION);
    it.delta_x = dx;
    it.delta_y = dy;
    it.buttons = btn;
    send_item(it);
  endtask

  // any known command, or a byte the device does not know
  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 8))
      0: return ps2md_pkg::CMD_GET_ID;
      1: return ps2md_pkg::CMD_STATUS;
      2: return ps2md_pkg::CMD_SET_RATE;
      3: return ps2md_pkg::CMD_SET_RES;
      4: return ps2md_pkg::CMD_ENABLE;
      5: return ps2md_pkg::CMD_DISABLE;
      6: return ps2md_pkg::CMD_DEFAULTS;
      7: return ps2md_pkg::CMD_RESET;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // most commands, parameter handling, read of an empty queue, unused action
  task automatic test_command_set();
    send_cmd(ps2md_pkg::CMD_RESET);
    repeat (4) send_read();       // ack, self-test, id, then nothing left
    send_cmd(ps2md_pkg::CMD_SET_RATE);
    send_cmd(ps2md_pkg::CMD_RESET);          // taken as the rate, no reset
    send_cmd(ps2md_pkg::CMD_SET_RES);
    send_cmd(8'h00);
    send_cmd(ps2md_pkg::CMD_DISABLE);
    send_cmd(ps2md_pkg::CMD_DEFAULTS);
    send_cmd(8'h5A);              // unknown, ack only
    send_item(rand_item(ps2md_pkg::ACT_NONE));
  endtask

  // fill the queue: partial command reply, dropped packet, dropped reply
  task automatic test_queue_limits();
    send_cmd(ps2md_pkg::CMD_ENABLE);           // 8 bytes held
    send_cmd(ps2md_pkg::CMD_STATUS);           // 12
    send_motion(-16'sd128, 16'sd128, 2'b01);   // 15, both deltas clamp low
    send_cmd(ps2md_pkg::CMD_GET_ID);           // ack fits, id byte dropped
    send_motion(16'sd5, -16'sd5, 2'b10);       // no room for a packet
    send_cmd(ps2md_pkg::CMD_STATUS);           // nothing fits
    send_cmd(ps2md_pkg::CMD_RESET);            // flush, reporting off
  endtask

  // motion while disabled, extremes of both deltas including the most negative dy
  task automatic test_motion_packets();
    send_motion(16'sd100, 16'sd100, 2'b11);    // reporting off, ignored
    send_cmd(ps2md_pkg::CMD_ENABLE);
    send_motion(16'h7FFF, 16'h8000, 2'b11);
    send_motion(16'h8000, 16'h7FFF, 2'b00);
    send_read();
  endtask

  // mostly packet bursts drained by reads, mixed with commands and noise
  task automatic test_random_traffic();
    int start;
    int n;
    int k;
    logic [7:0] c;
    start = sent_items;
    send_cmd(ps2md_pkg::CMD_ENABLE);
    while (sent_items < start + RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 6);
          repeat (n) send_item(rand_item(ps2md_pkg::ACT_MOTION));
          k = $urandom_range(1, 3 * n + 2);
          repeat (k) send_read();
        end
        4, 5: begin
          c = pick_command();
          send_cmd(c);
          if (c == ps2md_pkg::CMD_SET_RATE || c == ps2md_pkg::CMD_SET_RES) begin
            send_cmd(8'($urandom_range(0, 255)));
          end
        end
        6: send_cmd(ps2md_pkg::CMD_ENABLE);
        7: begin
          k = $urandom_range(1, 8);
          repeat (k) send_read();
        end
        8: begin
          // raw noise, any action with any content
          k = $urandom_range(1, 4);
          repeat (k) send_item(rand_item(ps2md_pkg::action_t'($urandom_range(0, 3))));
        end
        default: begin
          if ($urandom_range(0, 3) == 0) send_cmd(ps2md_pkg::CMD_RESET);
          else send_cmd(ps2md_pkg::CMD_STATUS);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // reader pacing: random stall before each result, sometimes none for a while
  initial begin : rsp_pacing
    int gap;
    rsp_if.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      draw_gap(snk_calm, gap);
      @(negedge clk);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s expected %02h got %02h", $time, name, want, got);
    end
  endfunction

  // compare each taken result with the oldest prediction
  always @(posedge clk) begin : rsp_check
    dev_rsp_t got;
    dev_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.read_byte, rsp_if.byte_valid, rsp_if.irq_pulse,
             rsp_if.data_pending, rsp_if.overflow};
      if (rsp_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result %03h with none expected", $time, got);
      end else begin
        want = rsp_expected_q[0];
        rsp_expected_q.delete(0);
        check_field("read_byte", want.read_byte, got.read_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        check_field("irq_pulse", 8'(want.irq_pulse), 8'(got.irq_pulse));
        check_field("data_pending", 8'(want.data_pending), 8'(got.data_pending));
        check_field("overflow", 8'(want.overflow), 8'(got.overflow));
      end
    end
  end

  // a hang shows up as a long run of cycles without any handshake
  always @(posedge clk) begin : watchdog
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin : run
    req_if.valid    = 1'b0;
    req_if.action   = ps2md_pkg::ACT_CMD;
    req_if.cmd_byte = 8'h00;
    req_if.delta_x  = '0;
    req_if.delta_y  = '0;
    req_if.buttons  = 2'b00;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_command_set();
    test_queue_limits();
    test_motion_packets();
    test_random_traffic();

    @(negedge clk);
    req_if.valid <= 1'b0;
    // drain, then keep watching to catch any stray result
    while (rsp_expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0 && rsp_expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
